/* design/assert_macros.svh */
// Assertion macros shared by the derivative unit modules.
// The macros expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle check: when the condition holds, the consequence holds in the same cycle.
`define IZN_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("izn assertion failed");

// Next-cycle check: when the condition holds, the consequence holds in the cycle after.
`define IZN_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("izn assertion failed");

`endif

/* design/izn_pkg.sv */
// Package for the Izhikevich derivative unit: item types, register codes,
// fixed-point constants and the controller/datapath command types. No dependencies.
`default_nettype none

package izn_pkg;

	// Shared multiplier operand and product widths.
	localparam int unsigned MUL_W  = 33;
	localparam int unsigned PROD_W = 2 * MUL_W;
	// Accumulator width: a product reduced by 16 bits.
	localparam int unsigned ACC_W  = PROD_W - 16;

	// Q16.16 constants of the model.
	localparam logic signed [MUL_W-1:0] K_SQ    = 33'sd2621;
	localparam logic signed [MUL_W-1:0] K_LIN   = 33'sd268698;
	localparam logic signed [MUL_W-1:0] K_EINH  = 33'sd4915200;
	localparam logic signed [31:0]      K_BIAS  = 32'sd7077888;
	localparam logic signed [31:0]      K_THRESH = 32'sd1966080;

	// Configuration register indexes.
	typedef logic [2:0] cfg_index_t;
	localparam cfg_index_t CFG_RECOVERY_RATE        = 3'd0;
	localparam cfg_index_t CFG_RECOVERY_SENSITIVITY = 3'd1;
	localparam cfg_index_t CFG_RESET_POTENTIAL      = 3'd2;
	localparam cfg_index_t CFG_RECOVERY_JUMP        = 3'd3;
	localparam cfg_index_t CFG_NOISE_ON             = 3'd4;
	localparam cfg_index_t CFG_NOISE_DECAY          = 3'd5;
	localparam cfg_index_t CFG_NOISE_GAIN_EXC       = 3'd6;
	localparam cfg_index_t CFG_NOISE_GAIN_INH       = 3'd7;

	typedef struct packed {
		logic signed [31:0] recovery_rate;
		logic signed [31:0] recovery_sensitivity;
		logic signed [31:0] reset_potential;
		logic signed [31:0] recovery_jump;
		logic               noise_on;
		logic [15:0]        noise_decay;
		logic [15:0]        noise_gain_exc;
		logic [15:0]        noise_gain_inh;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] potential_in;
		logic signed [31:0] recovery_in;
		logic signed [31:0] applied_current;
		logic signed [15:0] noise_sample_exc;
		logic signed [15:0] noise_sample_inh;
	} item_t;

	typedef struct packed {
		logic signed [31:0] potential_out;
		logic signed [31:0] recovery_out;
		logic signed [31:0] potential_slope;
		logic signed [31:0] recovery_slope;
		logic               spike_reset;
	} result_t;

	// Operation issued to the shared multiplier.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_SQ,
		OP_LIN,
		OP_SQH,
		OP_SQL,
		OP_BV,
		OP_GE_DEC,
		OP_GE_KICK,
		OP_GI_DEC,
		OP_GI_KICK,
		OP_GE_CUR,
		OP_GI_CUR,
		OP_DU
	} mul_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_LIN,
		ST_SQH,
		ST_SQL,
		ST_BV,
		ST_GE_DEC,
		ST_GE_KICK,
		ST_GI_DEC,
		ST_GI_KICK,
		ST_GE_CUR,
		ST_GI_CUR,
		ST_GAP,
		ST_DU,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic    load;
		logic    finish;
		mul_op_t mul_op;
	} cmd_t;

	typedef struct packed {
		logic spike;
		logic noise_on;
	} status_t;

endpackage

`default_nettype wire

/* design/izn_ctrl.sv */
// Controller of the Izhikevich derivative unit: sequences the shared multiplier
// and owns both handshakes. Depends on izn_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module izn_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_stall,
	output logic                result_valid,
	input  wire                 result_stall,
	input  izn_pkg::status_t    status,
	output izn_pkg::cmd_t       cmd
);
	import izn_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands: at most one multiplier operation per cycle.
	always_comb begin
		state_d = state_q;
		cmd = '{load: 1'b0, finish: 1'b0, mul_op: OP_NONE};
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				if (status.spike) begin
					state_d = ST_FIN;
				end else begin
					cmd.mul_op = OP_SQ;
					state_d = ST_LIN;
				end
			end
			ST_LIN: begin
				cmd.mul_op = OP_LIN;
				state_d = ST_SQH;
			end
			ST_SQH: begin
				cmd.mul_op = OP_SQH;
				state_d = ST_SQL;
			end
			ST_SQL: begin
				cmd.mul_op = OP_SQL;
				state_d = ST_BV;
			end
			ST_BV: begin
				cmd.mul_op = OP_BV;
				state_d = status.noise_on ? ST_GE_DEC : ST_GAP;
			end
			ST_GE_DEC: begin
				cmd.mul_op = OP_GE_DEC;
				state_d = ST_GE_KICK;
			end
			ST_GE_KICK: begin
				cmd.mul_op = OP_GE_KICK;
				state_d = ST_GI_DEC;
			end
			ST_GI_DEC: begin
				cmd.mul_op = OP_GI_DEC;
				state_d = ST_GI_KICK;
			end
			ST_GI_KICK: begin
				cmd.mul_op = OP_GI_KICK;
				state_d = ST_GE_CUR;
			end
			ST_GE_CUR: begin
				cmd.mul_op = OP_GE_CUR;
				state_d = ST_GI_CUR;
			end
			ST_GI_CUR: begin
				cmd.mul_op = OP_GI_CUR;
				state_d = ST_DU;
			end
			ST_GAP: begin
				// The inner term of du is registered during this cycle.
				state_d = ST_DU;
			end
			ST_DU: begin
				cmd.mul_op = OP_DU;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || !result_stall) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Result register valid flag; a finished item may replace one being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;

	`IZN_ASSERT_SAME(a_finish_room, cmd.finish, !result_valid || !result_stall)
	`IZN_ASSERT_NEXT(a_accept_starts, item_valid && !item_stall, state_q == ST_SQ)
	`IZN_ASSERT_NEXT(a_finish_shows, cmd.finish, result_valid)

endmodule

`default_nettype wire

/* design/izn_dp.sv */
// Datapath of the Izhikevich derivative unit: item registers, the shared
// 33x33 multiplier, accumulators, conductance state and the result register.
// Depends on izn_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module izn_dp (
	input  wire                 clk,
	input  wire                 arst_n,
	input  izn_pkg::cfg_t       cfg,
	input  izn_pkg::item_t      item,
	input  izn_pkg::cmd_t       cmd,
	output izn_pkg::status_t    status,
	output izn_pkg::result_t    result
);
	import izn_pkg::*;

	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'sh7FFF_FFFF);
	localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(32'sh8000_0000);

	// Saturate a wide signed value to the 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
		logic signed [31:0] r;
		if (x > SAT_MAX) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < SAT_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	// Clamp a conductance sum to [0, 2^31-1].
	function automatic logic signed [31:0] clamp_g(input logic signed [32:0] x);
		logic signed [31:0] r;
		if (x[32]) begin
			r = 32'sd0;
		end else if (x[31]) begin
			r = 32'sh7FFF_FFFF;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	// Item registers.
	logic signed [31:0] v_q;
	logic signed [31:0] u_q;
	logic signed [15:0] se_q;
	logic signed [15:0] si_q;
	logic               spike_q;

	// Working registers.
	logic signed [31:0]       ge_q;
	logic signed [31:0]       gi_q;
	logic signed [31:0]       gacc_q;
	logic signed [31:0]       inner_q;
	logic [30:0]              sqh_q;
	logic [15:0]              sql_q;
	logic signed [PROD_W-1:0] prod_q;
	mul_op_t                  tag_q;
	logic signed [ACC_W-1:0]  dv_q;
	result_t                  result_q;

	// Combinational signals.
	logic signed [MUL_W-1:0]  v_x;
	logic signed [MUL_W-1:0]  opa;
	logic signed [MUL_W-1:0]  opb;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [ACC_W-1:0]  prod_sh;
	logic signed [32:0]       gsum;

	assign v_x = {v_q[31], v_q};

	// Operand selection for the shared multiplier.
	always_comb begin
		case (cmd.mul_op)
			OP_SQ: begin
				opa = v_x;
				opb = v_x;
			end
			OP_LIN: begin
				opa = v_x;
				opb = K_LIN;
			end
			OP_SQH: begin
				opa = {2'b00, sqh_q};
				opb = K_SQ;
			end
			OP_SQL: begin
				opa = {17'd0, sql_q};
				opb = K_SQ;
			end
			OP_BV: begin
				opa = {cfg.recovery_sensitivity[31], cfg.recovery_sensitivity};
				opb = v_x;
			end
			OP_GE_DEC: begin
				opa = {ge_q[31], ge_q};
				opb = {17'd0, cfg.noise_decay};
			end
			OP_GE_KICK: begin
				opa = {17'd0, cfg.noise_gain_exc};
				opb = {{17{se_q[15]}}, se_q};
			end
			OP_GI_DEC: begin
				opa = {gi_q[31], gi_q};
				opb = {17'd0, cfg.noise_decay};
			end
			OP_GI_KICK: begin
				opa = {17'd0, cfg.noise_gain_inh};
				opb = {{17{si_q[15]}}, si_q};
			end
			OP_GE_CUR: begin
				opa = {ge_q[31], ge_q};
				opb = v_x;
			end
			OP_GI_CUR: begin
				opa = {gi_q[31], gi_q};
				opb = v_x + K_EINH;
			end
			OP_DU: begin
				opa = {cfg.recovery_rate[31], cfg.recovery_rate};
				opb = {inner_q[31], inner_q};
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign prod_d  = opa * opb;
	// Floor of the registered product over 2^16.
	assign prod_sh = prod_q[PROD_W-1:16];
	// Decayed conductance plus its noise kick.
	assign gsum    = {gacc_q[31], gacc_q} + prod_sh[32:0];

	// Product register, conductance state and operation tag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
			tag_q  <= OP_NONE;
			ge_q   <= '0;
			gi_q   <= '0;
		end else begin
			tag_q <= cmd.mul_op;
			if (cmd.mul_op != OP_NONE) begin
				prod_q <= prod_d;
			end
			if (tag_q == OP_GE_KICK) begin
				ge_q <= clamp_g(gsum);
			end
			if (tag_q == OP_GI_KICK) begin
				gi_q <= clamp_g(gsum);
			end
		end
	end

	// Item capture and consumption of each product in the cycle after it is formed.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q     <= item.potential_in;
			u_q     <= item.recovery_in;
			se_q    <= item.noise_sample_exc;
			si_q    <= item.noise_sample_inh;
			spike_q <= (item.potential_in > K_THRESH);
			dv_q    <= ACC_W'(K_BIAS) - ACC_W'(item.recovery_in)
				+ ACC_W'(item.applied_current);
		end else begin
			case (tag_q)
				OP_SQ: begin
					sqh_q <= prod_q[62:32];
					sql_q <= prod_q[31:16];
				end
				OP_LIN: begin
					dv_q <= dv_q + prod_sh;
				end
				OP_SQH: begin
					// The high half already carries the 2^16 scale.
					dv_q <= dv_q + prod_q[ACC_W-1:0];
				end
				OP_SQL: begin
					dv_q <= dv_q + prod_sh;
				end
				OP_BV: begin
					inner_q <= sat32(prod_sh - ACC_W'(u_q));
				end
				OP_GE_DEC: begin
					gacc_q <= prod_sh[31:0];
				end
				OP_GI_DEC: begin
					gacc_q <= prod_sh[31:0];
				end
				OP_GE_CUR: begin
					dv_q <= dv_q - prod_sh;
				end
				OP_GI_CUR: begin
					dv_q <= dv_q - prod_sh;
				end
				default: begin
				end
			endcase
		end
	end

	// Result register; on a spike the potential is reset and the jump applied.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (spike_q) begin
				result_q.potential_out   <= cfg.reset_potential;
				result_q.recovery_out    <= sat32(ACC_W'(u_q) + ACC_W'(cfg.recovery_jump));
				result_q.potential_slope <= 32'sd0;
				result_q.recovery_slope  <= 32'sd0;
				result_q.spike_reset     <= 1'b1;
			end else begin
				result_q.potential_out   <= v_q;
				result_q.recovery_out    <= u_q;
				result_q.potential_slope <= sat32(dv_q);
				result_q.recovery_slope  <= sat32(prod_sh);
				result_q.spike_reset     <= 1'b0;
			end
		end
	end

	assign result          = result_q;
	assign status.spike    = spike_q;
	assign status.noise_on = cfg.noise_on;

	`IZN_ASSERT_SAME(a_cond_nonneg, 1'b1, !ge_q[31] && !gi_q[31])
	`IZN_ASSERT_NEXT(a_prod_hold, cmd.mul_op == OP_NONE, $stable(prod_q))
	`IZN_ASSERT_NEXT(a_spike_result, cmd.finish && spike_q, result_q.spike_reset && result_q.potential_slope == 32'sd0 && result_q.recovery_slope == 32'sd0)

endmodule

`default_nettype wire

/* design/izhikevich_neuron_derivative_unit.sv */
// Top level of the Izhikevich derivative unit: configuration registers and
// the controller and datapath instances. Depends on izn_pkg, izn_ctrl and izn_dp.
//
// One item (V, u, Iapp and two noise samples) yields one result item with the
// possibly reset V and u and the saturated slopes dV and du, all Q16.16. All
// products go through a single 33x33 multiplier, at most one product per cycle,
// so the item time follows the product count: 12 products with noise on, 6 with
// noise off, and none for a spike item. The excitatory and inhibitory
// conductances live inside the block and are cleared by reset. A finished
// result sits in an output register, so the next item is accepted while the
// previous result still waits. The user must write configuration only while
// idle; the block itself does not enforce it.
`default_nettype none

module izhikevich_neuron_derivative_unit (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   item_valid,
	output logic                  item_stall,
	input  izn_pkg::item_t        item,
	output logic                  result_valid,
	input  wire                   result_stall,
	output izn_pkg::result_t      result,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  izn_pkg::cfg_index_t   cfg_index,
	input  wire [31:0]            cfg_data
);
	import izn_pkg::*;

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t status;

	// Configuration registers, written by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.recovery_rate        <= 32'sd1311;
			cfg_q.recovery_sensitivity <= -32'sd6554;
			cfg_q.reset_potential      <= -32'sd3604480;
			cfg_q.recovery_jump        <= 32'sd393216;
			cfg_q.noise_on             <= 1'b1;
			cfg_q.noise_decay          <= 16'd57835;
			cfg_q.noise_gain_exc       <= 16'd1950;
			cfg_q.noise_gain_inh       <= 16'd1950;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RECOVERY_RATE:        cfg_q.recovery_rate        <= cfg_data;
				CFG_RECOVERY_SENSITIVITY: cfg_q.recovery_sensitivity <= cfg_data;
				CFG_RESET_POTENTIAL:      cfg_q.reset_potential      <= cfg_data;
				CFG_RECOVERY_JUMP:        cfg_q.recovery_jump        <= cfg_data;
				CFG_NOISE_ON:             cfg_q.noise_on             <= cfg_data[0];
				CFG_NOISE_DECAY:          cfg_q.noise_decay          <= cfg_data[15:0];
				CFG_NOISE_GAIN_EXC:       cfg_q.noise_gain_exc       <= cfg_data[15:0];
				CFG_NOISE_GAIN_INH:       cfg_q.noise_gain_inh       <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Register writes complete in the cycle they are offered.
	assign cfg_ready = 1'b1;

	izn_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	izn_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

endmodule

`default_nettype wire

/* verif/tb_izhikevich_neuron_derivative_unit.sv */
// Testbench for izhikevich_neuron_derivative_unit. It predicts spike resets, noise
// conductances and slopes on its own and checks every result item in order.
// Depends on izn_pkg and the unit's RTL.

module tb_izhikevich_neuron_derivative_unit;
	import izn_pkg::*;

	// Q16.16 constants of the neuron equations.
	localparam longint Q_SQ     = 2621;
	localparam longint Q_LIN    = 268698;
	localparam longint Q_BIAS   = 7077888;
	localparam longint Q_THRESH = 1966080;
	localparam longint Q_EINH   = 4915200;
	localparam longint S32_MAX  = 64'sd2147483647;
	localparam longint S32_MIN  = -64'sd2147483648;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 166;

	// Predicts each result item of the neuron step and holds them until they arrive.
	class derivative_check;
		logic signed [31:0] rate_a, sens_b, reset_c, jump_d;
		logic               noise_en;
		logic        [15:0] decay, gain_exc, gain_inh;
		longint             g_exc, g_inh;
		result_t            due_results[$];
		int                 errors;

		function new();
			rate_a   = 32'sd1311;
			sens_b   = -32'sd6554;
			reset_c  = -32'sd3604480;
			jump_d   = 32'sd393216;
			noise_en = 1'b1;
			decay    = 16'd57835;
			gain_exc = 16'd1950;
			gain_inh = 16'd1950;
			g_exc    = 0;
			g_inh    = 0;
			errors   = 0;
		endfunction

		function void set_register(cfg_index_t idx, logic [31:0] data);
			case (idx)
				CFG_RECOVERY_RATE:        rate_a = data;
				CFG_RECOVERY_SENSITIVITY: sens_b = data;
				CFG_RESET_POTENTIAL:      reset_c = data;
				CFG_RECOVERY_JUMP:        jump_d = data;
				CFG_NOISE_ON:             noise_en = data[0];
				CFG_NOISE_DECAY:          decay = data[15:0];
				CFG_NOISE_GAIN_EXC:       gain_exc = data[15:0];
				CFG_NOISE_GAIN_INH:       gain_inh = data[15:0];
				default: ;
			endcase
		endfunction

		// Rescale by 2^16, rounding toward minus infinity.
		function longint floor16(longint x);
			return x >>> 16;
		endfunction

		function longint clamp32(longint x);
			if (x > S32_MAX)
				return S32_MAX;
			if (x < S32_MIN)
				return S32_MIN;
			return x;
		endfunction

		// One noise step of a conductance: decay, kick, clamp to [0, 2^31-1].
		function longint advance(longint g, logic [15:0] gain, logic signed [15:0] s);
			longint n;
			n = floor16(g * longint'(decay)) + floor16(longint'(gain) * longint'(s));
			if (n < 0)
				n = 0;
			if (n > S32_MAX)
				n = S32_MAX;
			return n;
		endfunction

		function void take_item(item_t x);
			longint  v, u, iapp, vsq, dv, du, inner;
			result_t r;
			v = longint'(x.potential_in);
			u = longint'(x.recovery_in);
			iapp = longint'(x.applied_current);
			r = '0;
			if (v > Q_THRESH) begin
				// Spike: reset V, jump u, leave the conductances alone.
				r.potential_out = reset_c;
				r.recovery_out = 32'(clamp32(u + longint'(jump_d)));
				r.spike_reset = 1'b1;
			end else begin
				vsq = floor16(v * v);
				dv = floor16(vsq * Q_SQ) + floor16(v * Q_LIN) + Q_BIAS - u + iapp;
				if (noise_en) begin
					g_exc = advance(g_exc, gain_exc, x.noise_sample_exc);
					g_inh = advance(g_inh, gain_inh, x.noise_sample_inh);
					dv -= floor16(g_exc * v);
					dv -= floor16(g_inh * (v + Q_EINH));
				end
				inner = clamp32(floor16(longint'(sens_b) * v) - u);
				du = floor16(longint'(rate_a) * inner);
				r.potential_out = x.potential_in;
				r.recovery_out = x.recovery_in;
				r.potential_slope = 32'(clamp32(dv));
				r.recovery_slope = 32'(clamp32(du));
			end
			due_results = {due_results, r};
		endfunction

		function void complain(string field, logic signed [31:0] want,
				logic signed [31:0] got);
			errors++;
			if (errors <= 10)
				$display("%s: expected %0d, got %0d", field, want, got);
		endfunction

		function void take_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				complain("unexpected result item, potential_out", 0, got.potential_out);
				return;
			end
			want = due_results.pop_front();
			if (got.potential_out !== want.potential_out)
				complain("potential_out", want.potential_out, got.potential_out);
			if (got.recovery_out !== want.recovery_out)
				complain("recovery_out", want.recovery_out, got.recovery_out);
			if (got.potential_slope !== want.potential_slope)
				complain("potential_slope", want.potential_slope, got.potential_slope);
			if (got.recovery_slope !== want.recovery_slope)
				complain("recovery_slope", want.recovery_slope, got.recovery_slope);
			if (got.spike_reset !== want.spike_reset)
				complain("spike_reset", 32'(want.spike_reset), 32'(got.spike_reset));
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_index_t  cfg_index = CFG_RECOVERY_RATE;
	logic [31:0] cfg_data = '0;
	int          send_pct = 0;
	int          recv_pct = 0;
	int unsigned cycle_count = 0;
	derivative_check board = new();

	izhikevich_neuron_derivative_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver stalls at random, decided at each falling edge.
	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < recv_pct);
	end

	// Every accepted result item is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.take_result(result);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("izhikevich_neuron_derivative_unit: mismatch");
			$finish;
		end
	end

	// Offers one item after random idle cycles; returns at the falling edge after
	// acceptance with valid still high.
	task automatic send_item(input item_t x);
		while ($urandom_range(99) < send_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= x;
		do @(posedge clk); while (item_stall);
		board.take_item(x);
		@(negedge clk);
	endtask

	// Holds the sender off until every predicted result item has arrived.
	task automatic wait_for_results();
		item_valid <= 1'b0;
		do @(negedge clk); while (board.pending() != 0);
	endtask

	task automatic write_register(input cfg_index_t idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.set_register(idx, data);
		@(negedge clk);
	endtask

	// Writes all registers: defaults, both extremes, noise off, maximum noise parameters and random sets.
	task automatic apply_setting(input int which);
		int          a, b, c, d;
		logic        on;
		logic [15:0] dec, ge, gi;
		a = 1311;
		b = -6554;
		c = -3604480;
		d = 393216;
		on = 1'b1;
		dec = 16'd57835;
		ge = 16'd1950;
		gi = 16'd1950;
		case (which)
			1: begin
				a = 32'h7FFFFFFF;
				b = 32'h7FFFFFFF;
				c = 32'h7FFFFFFF;
				d = 32'h7FFFFFFF;
				dec = 16'hFFFF;
				ge = 16'hFFFF;
				gi = 16'hFFFF;
			end
			2: begin
				a = 32'h80000000;
				b = 32'h80000000;
				c = 32'h80000000;
				d = 32'h80000000;
				dec = 16'h0000;
				ge = 16'h0000;
				gi = 16'h0000;
			end
			3: on = 1'b0;
			4, 6: begin
				a = $urandom;
				b = $urandom;
				c = $urandom;
				d = $urandom;
				on = 1'($urandom_range(1));
				dec = 16'($urandom_range(65535));
				ge = 16'($urandom_range(65535));
				gi = 16'($urandom_range(65535));
			end
			5: begin
				dec = 16'hFFFF;
				ge = 16'hFFFF;
				gi = 16'hFFFF;
			end
			default: ;
		endcase
		write_register(CFG_RECOVERY_RATE, a);
		write_register(CFG_RECOVERY_SENSITIVITY, b);
		write_register(CFG_RESET_POTENTIAL, c);
		write_register(CFG_RECOVERY_JUMP, d);
		write_register(CFG_NOISE_ON, {31'd0, on});
		write_register(CFG_NOISE_DECAY, {16'd0, dec});
		write_register(CFG_NOISE_GAIN_EXC, {16'd0, ge});
		write_register(CFG_NOISE_GAIN_INH, {16'd0, gi});
		cfg_valid <= 1'b0;
	endtask

	function automatic item_t pack_item(int v, int u, int iapp, logic [15:0] se,
			logic [15:0] si);
		item_t x;
		x.potential_in = v;
		x.recovery_in = u;
		x.applied_current = iapp;
		x.noise_sample_exc = se;
		x.noise_sample_inh = si;
		return x;
	endfunction

	// Mostly physiological values, some around the threshold, the rest full range.
	function automatic item_t random_item();
		int unsigned pick;
		item_t       x;
		pick = $urandom_range(99);
		x.noise_sample_exc = 16'($urandom_range(65535));
		x.noise_sample_inh = 16'($urandom_range(65535));
		if (pick < 65) begin
			x.potential_in = int'($urandom_range(130 * 65536)) - 100 * 65536;
			x.recovery_in = int'($urandom_range(40 * 65536)) - 20 * 65536;
			x.applied_current = int'($urandom_range(40 * 65536)) - 10 * 65536;
		end else if (pick < 80) begin
			x.potential_in = 1966080 + int'($urandom_range(8)) - 4;
			x.recovery_in = int'($urandom_range(40 * 65536)) - 20 * 65536;
			x.applied_current = $urandom;
		end else begin
			x.potential_in = $urandom;
			x.recovery_in = $urandom;
			x.applied_current = $urandom;
		end
		return x;
	endfunction

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed items at the reset register values, noise on.
		send_item(pack_item(0, 0, 0, 16'h0000, 16'h0000));
		// Exactly 30 does not spike; one step above does.
		send_item(pack_item(1966080, -13 * 65536, 0, 16'h7FFF, 16'h8000));
		send_item(pack_item(1966081, -13 * 65536, 0, 16'h7FFF, 16'h7FFF));
		// Spike with the recovery jump overflowing.
		send_item(pack_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 16'hFFFF));
		// Most negative inputs: slopes saturate, conductances clamp at zero.
		send_item(pack_item(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000));
		// Let the conductances build up over a few resting steps.
		for (int k = 0; k < 5; k++)
			send_item(pack_item((-65 + 2 * k) * 65536, -13 * 65536, 10 * 65536,
				16'h7FFF, 16'h7FFF));
		// Spike between noisy steps leaves the conductances as they are.
		send_item(pack_item(40 * 65536, -13 * 65536, 0, 16'h7FFF, 16'h7FFF));
		// At the inhibitory reversal potential.
		send_item(pack_item(-75 * 65536, 0, 0, 16'h7FFF, 16'h0000));
		send_item(pack_item(1966080, 32'h80000000, 32'h7FFFFFFF, 16'h8000, 16'h7FFF));
		// Small negative values exercise rounding toward minus infinity.
		send_item(pack_item(-1, -1, -1, 16'hFFFF, 16'hFFFF));
		send_item(pack_item(1, 1, 1, 16'h0001, 16'h0001));
		wait_for_results();

		// Noise off: conductances hold and add no current.
		write_register(CFG_NOISE_ON, 32'd0);
		cfg_valid <= 1'b0;
		send_item(pack_item(-65 * 65536, -13 * 65536, 0, 16'h7FFF, 16'h7FFF));
		send_item(pack_item(32'h80000000, 0, 0, 16'h8000, 16'h8000));
		send_item(pack_item(1966081, 0, 0, 16'h7FFF, 16'h7FFF));
		wait_for_results();

		// Random phases under varying registers and idle patterns.
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin
					send_pct = 0;
					recv_pct = 0;
				end
				1: begin
					send_pct = 83;
					recv_pct = 0;
				end
				2: begin
					send_pct = 0;
					recv_pct = 83;
				end
				default: begin
					send_pct = 28;
					recv_pct = 28;
				end
			endcase
			apply_setting(p);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					wait_for_results();
				send_item(random_item());
			end
			wait_for_results();
		end

		repeat (20) @(negedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("izhikevich_neuron_derivative_unit: match");
		else
			$display("izhikevich_neuron_derivative_unit: mismatch");
		$finish;
	end

endmodule
